FILE: sv/scc_pkg.sv
// shared types, constants and arithmetic helpers of the separable convolution block
`default_nettype none
package scc_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_RADIUS   = 3;
  localparam int PIXEL_BITS   = 16;
  localparam int TAP_FRACTION = 14;
  localparam int ROW_LIMIT    = 4096;
  localparam int WIN          = 2 * MAX_RADIUS + 1;
  localparam int SLOTS        = 2 * MAX_RADIUS;
  localparam int MEM_DEPTH    = SLOTS * MAX_WIDTH;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int COL_W        = 11;
  localparam int ROW_W        = 12;
  localparam int WREG_W       = 12;
  localparam int HREG_W       = 13;
  localparam int CFG_W        = 64;
  localparam int IDX_W        = 3;
  localparam int ACC_W        = 36;
  localparam int TAP_CNT_W    = 3;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW_RAD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_COL_RAD   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RTAP_LO   = 3'd4;
  localparam logic [IDX_W-1:0] REG_RTAP_HI   = 3'd5;
  localparam logic [IDX_W-1:0] REG_CTAP_LO   = 3'd6;
  localparam logic [IDX_W-1:0] REG_CTAP_HI   = 3'd7;

  localparam logic kind_pixel = 1'b0;
  localparam logic kind_flush = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0]                 wm1;
    logic [ROW_W-1:0]                 hm1;
    logic [HREG_W-1:0]                h;
    logic [1:0]                       rr;
    logic [1:0]                       cr;
    logic [WIN-1:0][PIXEL_BITS-1:0]   rtap;
    logic [WIN-1:0][PIXEL_BITS-1:0]   ctap;
  } cfg_t;

  typedef struct packed {
    logic                             flush;
    logic                             emit;
    logic                             last;
    logic                             row_end;
    logic                             frame_end;
    logic [COL_W-1:0]                 c;
    logic [COL_W-1:0]                 x;
    logic [ROW_W-1:0]                 yin;
    logic [ROW_W-1:0]                 y;
    logic [WIN-1:0][PIXEL_BITS-1:0]   win;
  } job_t;

  // row number modulo the slot count, reciprocal multiply, exact below 8192
  function automatic logic [2:0] mod_slots(input logic [HREG_W-1:0] v);
    logic [26:0]       p;
    logic [HREG_W-1:0] q;
    logic [HREG_W-1:0] rem;
    p   = {14'b0, v} * 27'd10923;
    q   = {2'b0, p[26:16]};
    rem = v - q * HREG_W'(SLOTS);
    return rem[2:0];
  endfunction

  // round half up, shift and saturate; returns {clipped, value}
  function automatic logic [PIXEL_BITS:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] xr;
    logic signed [ACC_W-1:0] q;
    logic                    sat;
    logic [PIXEL_BITS-1:0]   val;
    xr = acc + (ACC_W'(1) <<< (TAP_FRACTION - 1));
    q  = xr >>> TAP_FRACTION;
    if (q > ACC_W'((1 <<< (PIXEL_BITS - 1)) - 1)) begin
      sat = 1'b1;
      val = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    end else if (q < -(ACC_W'(1) <<< (PIXEL_BITS - 1))) begin
      sat = 1'b1;
      val = {1'b1, {(PIXEL_BITS-1){1'b0}}};
    end else begin
      sat = 1'b0;
      val = q[PIXEL_BITS-1:0];
    end
    return {sat, val};
  endfunction

endpackage
`default_nettype wire

FILE: sv/scc_if.sv
// stream interfaces of the input items and the result items
`default_nettype none
interface scc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pixel;
  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface scc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        row_end;
  logic        frame_end;
  logic        saturated;
  logic        last;
  modport source (output valid, output value, output row_end, output frame_end,
                  output saturated, output last, input ready);
  modport sink   (input valid, input value, input row_end, input frame_end,
                  input saturated, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/scc_front.sv
// front end: accepts items, tracks raster position and issues column jobs
`default_nettype none
module scc_front
  import scc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  scc_in_if.sink    in_i,
  output job_t      job_o,
  output logic      job_valid_o,
  input  wire logic job_ready_i
);

  logic [WIN-1:0][PIXEL_BITS-1:0] win_q, win_d;
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             drain_q, drain_d;
  logic             busy_q, busy_d;
  logic [COL_W-1:0] gc_q, gc_d, gend_q, gend_d, gx_q, gx_d;
  logic [ROW_W-1:0] gyin_q, gyin_d, gy_q, gy_d;
  logic             gflush_q, gflush_d, gemit_q, gemit_d;

  logic                    acc_in;
  logic [COL_W-1:0]        col_b, x, fc;
  logic [ROW_W-1:0]        row_b, yin, fy;
  logic                    row_last, fre, ffe;
  logic signed [COL_W+1:0] first;

  assign in_i.ready = !busy_q;
  assign acc_in     = in_i.valid && !busy_q;

  always_comb begin
    col_b = drain_q ? '0 : in_col_q;
    row_b = drain_q ? '0 : in_row_q;
    x     = (col_b > cfg_i.wm1) ? cfg_i.wm1 : col_b;
    yin   = (row_b > cfg_i.hm1) ? cfg_i.hm1 : row_b;
    row_last = (x == cfg_i.wm1);
    first = $signed({2'b0, x}) - $signed({{COL_W{1'b0}}, cfg_i.rr});
    if (row_last && first < 0) first = '0;
    fy  = (out_row_q > cfg_i.hm1) ? cfg_i.hm1 : out_row_q;
    fc  = (out_col_q > cfg_i.wm1) ? cfg_i.wm1 : out_col_q;
    fre = (fc == cfg_i.wm1);
    ffe = fre && (fy == cfg_i.hm1);
  end

  always_comb begin
    win_d = win_q; in_col_d = in_col_q; in_row_d = in_row_q;
    out_col_d = out_col_q; out_row_d = out_row_q; drain_d = drain_q;
    busy_d = busy_q; gc_d = gc_q; gend_d = gend_q; gx_d = gx_q;
    gyin_d = gyin_q; gy_d = gy_q; gflush_d = gflush_q; gemit_d = gemit_q;
    if (busy_q && job_ready_i) begin
      if (gc_q == gend_q) busy_d = 1'b0;
      else gc_d = gc_q + COL_W'(1);
    end
    if (acc_in) begin
      if (in_i.kind == kind_flush) begin
        if (drain_q) begin
          busy_d = 1'b1; gflush_d = 1'b1; gemit_d = 1'b1;
          gc_d = fc; gend_d = fc; gy_d = fy; gx_d = '0; gyin_d = '0;
          out_col_d = fc + COL_W'(1);
          if (fre) begin
            out_col_d = '0;
            out_row_d = fy + ROW_W'(1);
          end
          if (ffe) begin
            out_row_d = '0;
            drain_d   = 1'b0;
          end
        end
      end else begin
        drain_d = 1'b0;
        if (drain_q) begin
          out_row_d = '0; out_col_d = '0;
        end
        win_d = {win_q[WIN-2:0], in_i.pixel};
        gflush_d = 1'b0;
        gemit_d  = (yin >= ROW_W'(cfg_i.cr));
        gy_d     = yin - ROW_W'(cfg_i.cr);
        gx_d = x; gyin_d = yin;
        gc_d = first[COL_W-1:0]; gend_d = row_last ? x : first[COL_W-1:0];
        busy_d = row_last || (first >= 0);
        in_col_d = x + COL_W'(1);
        in_row_d = yin;
        if (row_last) begin
          in_col_d = '0;
          in_row_d = yin + ROW_W'(1);
          if (yin == cfg_i.hm1) begin
            in_row_d = '0;
            if (cfg_i.cr != 2'd0) begin
              drain_d   = 1'b1;
              out_row_d = (cfg_i.h > HREG_W'(cfg_i.cr)) ?
                          ROW_W'(cfg_i.h - HREG_W'(cfg_i.cr)) : '0;
              out_col_d = '0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    job_o.flush     = gflush_q;
    job_o.emit      = gemit_q;
    job_o.last      = (gc_q == gend_q);
    job_o.row_end   = (gc_q == cfg_i.wm1);
    job_o.frame_end = (gc_q == cfg_i.wm1) && (gy_q == cfg_i.hm1);
    job_o.c         = gc_q;
    job_o.x         = gx_q;
    job_o.yin       = gyin_q;
    job_o.y         = gy_q;
    job_o.win       = win_q;
  end
  assign job_valid_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; in_col_q <= '0; in_row_q <= '0; out_col_q <= '0;
      out_row_q <= '0; drain_q <= 1'b0; busy_q <= 1'b0;
    end else begin
      win_q <= win_d; in_col_q <= in_col_d; in_row_q <= in_row_d;
      out_col_q <= out_col_d; out_row_q <= out_row_d; drain_q <= drain_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gc_q <= gc_d; gend_q <= gend_d; gx_q <= gx_d; gyin_q <= gyin_d;
    gy_q <= gy_d; gflush_q <= gflush_d; gemit_q <= gemit_d;
  end

endmodule
`default_nettype wire

FILE: sv/scc_queue.sv
// two-entry job queue between front and back
`default_nettype none
module scc_queue
  import scc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t push_data_i,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  output job_t      pop_data_o,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i
);

  job_t       ent_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q, push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

FILE: sv/scc_back.sv
// back end: shared multiply-accumulate for both passes, line store, result register
`default_nettype none
module scc_back
  import scc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire job_t job_i,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  scc_out_if.source out_o
);

  typedef enum logic [7:0] {
    B_IDLE = 8'b0000_0001,
    B_H    = 8'b0000_0010,
    B_HFIN = 8'b0000_0100,
    B_VA   = 8'b0000_1000,
    B_VB   = 8'b0001_0000,
    B_VFIN = 8'b0010_0000,
    B_WR   = 8'b0100_0000
  } back_state_e;

  back_state_e st_q, st_d;
  job_t        job_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [TAP_CNT_W-1:0]    k_q, k_d;
  logic [PIXEL_BITS-1:0]   hv_q;
  logic                    hsat_q, clip_q, clip_d, cur_q;
  logic [PIXEL_BITS:0]     rd_q;
  logic [PIXEL_BITS:0]     mem [MEM_DEPTH];

  logic [PIXEL_BITS-1:0]   ov_q;
  logic                    ovalid_q, ore_q, ofe_q, osat_q, olast_q;

  logic signed [COL_W+2:0] hj, hd, vj;
  logic [COL_W-1:0]        hjc;
  logic [2:0]              hdc;
  logic [ROW_W-1:0]        vjc;
  logic                    vcur;
  logic [ADDR_W-1:0]       raddr, waddr;
  logic signed [PIXEL_BITS-1:0] tap, smp;
  logic signed [2*PIXEL_BITS-1:0] prod;
  logic [PIXEL_BITS:0]     fin;
  logic                    out_free, rd_en, wr_en;

  assign job_ready_o = (st_q == B_IDLE);
  assign out_free    = !ovalid_q || out_o.ready;
  assign fin         = finish(acc_q);

  always_comb begin
    // horizontal tap position, clamped to the row, then to the window
    hj  = $signed({3'b0, job_q.c}) - $signed({12'b0, cfg_i.rr})
          + $signed({11'b0, k_q});
    if (hj < 0) hjc = '0;
    else if (hj > $signed({3'b0, cfg_i.wm1})) hjc = cfg_i.wm1;
    else hjc = hj[COL_W-1:0];
    hd = $signed({3'b0, job_q.x}) - $signed({3'b0, hjc});
    if (hd < 0) hdc = '0;
    else if (hd > (COL_W+3)'(WIN - 1)) hdc = 3'(WIN - 1);
    else hdc = hd[2:0];
    // vertical row, clamped to the frame
    vj = $signed({2'b0, job_q.y}) - $signed({12'b0, cfg_i.cr})
         + $signed({11'b0, k_q});
    if (vj < 0) vjc = '0;
    else if (vj > $signed({2'b0, cfg_i.hm1})) vjc = cfg_i.hm1;
    else vjc = vj[ROW_W-1:0];
    vcur  = !job_q.flush && (vjc == job_q.yin);
    raddr = ADDR_W'(mod_slots({1'b0, vjc})) * ADDR_W'(MAX_WIDTH) + ADDR_W'(job_q.c);
    waddr = ADDR_W'(mod_slots({1'b0, job_q.yin})) * ADDR_W'(MAX_WIDTH)
            + ADDR_W'(job_q.c);
    if (st_q == B_H) begin
      tap = $signed(cfg_i.rtap[k_q]);
      smp = $signed(job_q.win[hdc]);
    end else begin
      tap = $signed(cfg_i.ctap[k_q]);
      smp = cur_q ? $signed(hv_q) : $signed(rd_q[PIXEL_BITS-1:0]);
    end
    prod = tap * smp;
  end

  always_comb begin
    st_d = st_q; acc_d = acc_q; k_d = k_q; clip_d = clip_q;
    rd_en = 1'b0; wr_en = 1'b0;
    case (st_q)
      B_IDLE: begin
        acc_d = '0; k_d = '0; clip_d = 1'b0;
        if (job_valid_i) st_d = job_i.flush ? B_VA : B_H;
      end
      B_H: begin
        acc_d = acc_q + ACC_W'(prod);
        if (k_q == {cfg_i.rr, 1'b0}) st_d = B_HFIN;
        else k_d = k_q + TAP_CNT_W'(1);
      end
      B_HFIN: begin
        acc_d = '0; k_d = '0;
        st_d = job_q.emit ? B_VA : B_WR;
      end
      B_VA: begin
        rd_en = 1'b1;
        st_d  = B_VB;
      end
      B_VB: begin
        acc_d  = acc_q + ACC_W'(prod);
        clip_d = clip_q | (cur_q ? hsat_q : rd_q[PIXEL_BITS]);
        if (k_q == {cfg_i.cr, 1'b0}) st_d = B_VFIN;
        else begin
          k_d  = k_q + TAP_CNT_W'(1);
          st_d = B_VA;
        end
      end
      B_VFIN: begin
        if (out_free) st_d = job_q.flush ? B_IDLE : B_WR;
      end
      B_WR: begin
        wr_en = 1'b1;
        st_d  = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_VFIN && out_free) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    k_q    <= k_d;
    clip_q <= clip_d;
    if (st_q == B_IDLE) job_q <= job_i;
    if (st_q == B_HFIN) begin
      hv_q   <= fin[PIXEL_BITS-1:0];
      hsat_q <= fin[PIXEL_BITS];
    end
    if (st_q == B_VA) cur_q <= vcur;
    if (st_q == B_VFIN && out_free) begin
      ov_q    <= fin[PIXEL_BITS-1:0];
      osat_q  <= clip_q | fin[PIXEL_BITS];
      ore_q   <= job_q.row_end;
      ofe_q   <= job_q.frame_end;
      olast_q <= job_q.last;
    end
  end

  // line store, one port used per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= {hsat_q, hv_q};
    if (rd_en) rd_q <= mem[raddr];
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.value     = ov_q;
  assign out_o.row_end   = ore_q;
  assign out_o.frame_end = ofe_q;
  assign out_o.saturated = osat_q;
  assign out_o.last      = olast_q;

endmodule
`default_nettype wire

FILE: sv/separable_conv2d_clamp_top.sv
// top level of the separable 2-d convolution with clamp-to-edge borders
// Raster pixels (kind 0) and flush ticks (kind 1) enter through in_i; filtered
// pixels leave through out_o with row, frame, clip and last-of-item flags. The
// front end takes one item and turns it into column jobs (one per pixel from
// column row_radius on, up to row_radius+1 at a row end, one per pending flush
// tick); a two-entry queue feeds the back end, which runs both passes on one
// shared multiply-accumulate and a single-port line store of six rows by 2048
// columns. A job runs the horizontal taps, then one line store read and one
// accumulate per row, then finishing, result load and line store write; a job
// that emits nothing skips the vertical rows and the result load, a flush job
// the horizontal part and the write. The line store needs no clearing after reset.
`default_nettype none
module separable_conv2d_clamp_top
  import scc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  scc_in_if.sink                in_i,
  scc_out_if.source             out_o
);

  // configuration registers
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic [1:0]        rrad_q, crad_q;
  logic [63:0]       rtlo_q, ctlo_q;
  logic [47:0]       rthi_q, cthi_q;
  cfg_t              cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WREG_W'(1); height_q <= HREG_W'(1);
      rrad_q <= '0; crad_q <= '0;
      rtlo_q <= 64'd16384; rthi_q <= '0;
      ctlo_q <= 64'd16384; cthi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:   width_q  <= cfg_data_i[WREG_W-1:0];
        REG_HEIGHT:  height_q <= cfg_data_i[HREG_W-1:0];
        REG_ROW_RAD: rrad_q   <= cfg_data_i[1:0];
        REG_COL_RAD: crad_q   <= cfg_data_i[1:0];
        REG_RTAP_LO: rtlo_q   <= cfg_data_i;
        REG_RTAP_HI: rthi_q   <= cfg_data_i[47:0];
        REG_CTAP_LO: ctlo_q   <= cfg_data_i;
        REG_CTAP_HI: cthi_q   <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize acts as the limit
  always_comb begin
    if (width_q == '0) cfg.wm1 = '0;
    else if (width_q > WREG_W'(MAX_WIDTH)) cfg.wm1 = COL_W'(MAX_WIDTH - 1);
    else cfg.wm1 = COL_W'(width_q - WREG_W'(1));
    if (height_q == '0) cfg.h = HREG_W'(1);
    else if (height_q > HREG_W'(ROW_LIMIT)) cfg.h = HREG_W'(ROW_LIMIT);
    else cfg.h = height_q;
    cfg.hm1 = ROW_W'(cfg.h - HREG_W'(1));
    cfg.rr  = rrad_q;
    cfg.cr  = crad_q;
    for (int t = 0; t < 4; t++) begin
      cfg.rtap[t] = rtlo_q[16*t +: 16];
      cfg.ctap[t] = ctlo_q[16*t +: 16];
    end
    for (int t = 4; t < WIN; t++) begin
      cfg.rtap[t] = rthi_q[16*(t-4) +: 16];
      cfg.ctap[t] = cthi_q[16*(t-4) +: 16];
    end
  end

  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  scc_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_i,
    .job_o(f_job), .job_valid_o(f_valid), .job_ready_i(f_ready)
  );

  // queue lets the front keep taking items while the back grinds on a job
  scc_queue u_queue (
    .clk_i, .rst_ni,
    .push_data_i(f_job), .push_valid_i(f_valid), .push_ready_o(f_ready),
    .pop_data_o(q_job), .pop_valid_o(q_valid), .pop_ready_i(q_ready)
  );

  scc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .job_i(q_job), .job_valid_i(q_valid), .job_ready_o(q_ready), .out_o
  );

endmodule
`default_nettype wire
